>>> rtl/vpad_pkg.sv
// ============================================================================
// Volume edge replicate pad: shared package
// Sizes, widths, register indexes and the decoded operation that travels
// from the front end through the queue to the back end.
// ============================================================================
`default_nettype none

package vpad_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_DEPTH  = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int VOXEL_W   = 8;

    localparam int X_W  = $clog2(MAX_WIDTH);
    localparam int Y_W  = $clog2(MAX_HEIGHT);
    localparam int Z_W  = $clog2(MAX_DEPTH);
    localparam int SX_W = $clog2(MAX_WIDTH + 1);
    localparam int SY_W = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W = $clog2(MAX_DEPTH + 1);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_DEPTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PADDED_WIDTH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PADDED_HEIGHT = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PADDED_DEPTH  = CFG_IDX_W'(5);

    localparam logic OP_SOURCE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] source_width;
        logic [CFG_W-1:0] source_height;
        logic [CFG_W-1:0] source_depth;
        logic [CFG_W-1:0] padded_width;
        logic [CFG_W-1:0] padded_height;
        logic [CFG_W-1:0] padded_depth;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_DIRECT  = 2'd0,
        KIND_REPLICA = 2'd1,
        KIND_REJECT  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [VOXEL_W-1:0]  value;
        logic [ADDR_W-1:0]   rd_addr;
        logic [ADDR_W-1:0]   wr_addr;
        logic                last;
    } pad_op_t;

endpackage

`default_nettype wire

>>> rtl/vpad_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module vpad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/vpad_front.sv
// ============================================================================
// Volume edge replicate pad: front end
// Tracks the raster position and the last source voxel of the row, checks
// each request against the position and decodes it into a store operation.
// ============================================================================
`default_nettype none

module vpad_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vpad_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic [vpad_pkg::VOXEL_W-1:0]  voxel_value,
    input  wire logic                          q_ready,
    output logic                               push,
    output vpad_pkg::pad_op_t                  op
);

    function automatic int unsigned clamp_dim(logic [vpad_pkg::CFG_W-1:0] v,
                                              int unsigned mx);
        int unsigned r;
        if (v == '0)
        begin
            r = 1;
        end
        else if (int'(v) > int'(mx))
        begin
            r = mx;
        end
        else
        begin
            r = int'(v);
        end
        return r;
    endfunction

    function automatic logic [vpad_pkg::ADDR_W-1:0] store_addr(
        logic [vpad_pkg::X_W-1:0] x, logic [vpad_pkg::Y_W-1:0] y);
        return vpad_pkg::ADDR_W'(y) * vpad_pkg::ADDR_W'(vpad_pkg::MAX_WIDTH)
             + vpad_pkg::ADDR_W'(x);
    endfunction

    logic [vpad_pkg::X_W-1:0]     pos_x_reg, pos_x_next;
    logic [vpad_pkg::Y_W-1:0]     pos_y_reg, pos_y_next;
    logic [vpad_pkg::Z_W-1:0]     pos_z_reg, pos_z_next;
    logic [vpad_pkg::VOXEL_W-1:0] row_last_reg, row_last_next;

    logic [vpad_pkg::SX_W-1:0] sw, pw_c, pw, x_ext, x_inc;
    logic [vpad_pkg::SY_W-1:0] sh, ph_c, ph, y_ext, y_inc;
    logic [vpad_pkg::SZ_W-1:0] sd, pd_c, pd, z_ext, z_inc;
    logic in_source, reject, wrap_x, wrap_y, wrap_z, accept;

    always_comb
    begin
        sw   = vpad_pkg::SX_W'(clamp_dim(cfg.source_width,  vpad_pkg::MAX_WIDTH));
        sh   = vpad_pkg::SY_W'(clamp_dim(cfg.source_height, vpad_pkg::MAX_HEIGHT));
        sd   = vpad_pkg::SZ_W'(clamp_dim(cfg.source_depth,  vpad_pkg::MAX_DEPTH));
        pw_c = vpad_pkg::SX_W'(clamp_dim(cfg.padded_width,  vpad_pkg::MAX_WIDTH));
        ph_c = vpad_pkg::SY_W'(clamp_dim(cfg.padded_height, vpad_pkg::MAX_HEIGHT));
        pd_c = vpad_pkg::SZ_W'(clamp_dim(cfg.padded_depth,  vpad_pkg::MAX_DEPTH));
        pw   = (pw_c < sw) ? sw : pw_c;
        ph   = (ph_c < sh) ? sh : ph_c;
        pd   = (pd_c < sd) ? sd : pd_c;

        x_ext = vpad_pkg::SX_W'(pos_x_reg);
        y_ext = vpad_pkg::SY_W'(pos_y_reg);
        z_ext = vpad_pkg::SZ_W'(pos_z_reg);
        x_inc = x_ext + vpad_pkg::SX_W'(1);
        y_inc = y_ext + vpad_pkg::SY_W'(1);
        z_inc = z_ext + vpad_pkg::SZ_W'(1);
        wrap_x = (x_inc >= pw);
        wrap_y = (y_inc >= ph);
        wrap_z = (z_inc >= pd);

        in_source = (x_ext < sw) && (y_ext < sh) && (z_ext < sd);
        reject    = in_source ? (opcode != vpad_pkg::OP_SOURCE)
                              : (opcode != vpad_pkg::OP_TICK);
    end

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign push     = accept;

    always_comb
    begin
        op.kind    = vpad_pkg::KIND_DIRECT;
        op.value   = voxel_value;
        op.wr_addr = store_addr(pos_x_reg, pos_y_reg);
        op.rd_addr = store_addr(pos_x_reg, pos_y_reg);
        op.last    = wrap_x && wrap_y && wrap_z;
        priority if (reject)
        begin
            op.kind  = vpad_pkg::KIND_REJECT;
            op.value = '0;
            op.last  = 1'b0;
        end
        else if (in_source)
        begin
            op.kind  = vpad_pkg::KIND_DIRECT;
        end
        else if (z_ext >= sd)
        begin
            op.kind  = vpad_pkg::KIND_REPLICA;
        end
        else if (y_ext >= sh)
        begin
            op.kind    = vpad_pkg::KIND_REPLICA;
            op.rd_addr = store_addr(pos_x_reg, pos_y_reg - vpad_pkg::Y_W'(1));
        end
        else
        begin
            op.kind  = vpad_pkg::KIND_DIRECT;
            op.value = row_last_reg;
        end
    end

    always_comb
    begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        row_last_next = row_last_reg;
        if (accept && !reject)
        begin
            if (in_source && (x_inc == sw))
            begin
                row_last_next = voxel_value;
            end
            if (wrap_x)
            begin
                pos_x_next = '0;
                if (wrap_y)
                begin
                    pos_y_next = '0;
                    pos_z_next = wrap_z ? '0 : vpad_pkg::Z_W'(z_inc);
                end
                else
                begin
                    pos_y_next = vpad_pkg::Y_W'(y_inc);
                end
            end
            else
            begin
                pos_x_next = vpad_pkg::X_W'(x_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            row_last_reg <= '0;
        end
        else
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            row_last_reg <= row_last_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vpad_queue.sv
// ============================================================================
// Volume edge replicate pad: operation queue
// A short first-in first-out queue of decoded operations between the front
// end and the back end.
// ============================================================================
`default_nettype none

module vpad_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire vpad_pkg::pad_op_t           push_op,
    output logic                             ready,
    input  wire logic                        pop,
    output logic                             valid,
    output vpad_pkg::pad_op_t                head,
    output logic [vpad_pkg::QCNT_W-1:0]      level
);

    vpad_pkg::pad_op_t               slot_reg [vpad_pkg::QUEUE_DEPTH];
    logic [vpad_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [vpad_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [vpad_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign ready = (count_reg != vpad_pkg::QCNT_W'(vpad_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign level = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vpad_pkg::QPTR_W'(vpad_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + vpad_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vpad_pkg::QPTR_W'(vpad_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + vpad_pkg::QPTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + vpad_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - vpad_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vpad_back.sv
// ============================================================================
// Volume edge replicate pad: back end
// Reads replicas from the slice store, resolves the voxel value, writes it
// back to the store and holds the result in the output register.
// ============================================================================
`default_nettype none

module vpad_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire vpad_pkg::pad_op_t             q_head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [vpad_pkg::VOXEL_W-1:0]  out_value,
    output logic                               last_of_volume,
    output logic                               status
);

    logic                          s1_valid_reg, s1_valid_next;
    vpad_pkg::pad_op_t             s1_op_reg, s1_op_next;
    logic                          fwd_hit_reg, fwd_hit_next;
    logic [vpad_pkg::VOXEL_W-1:0]  fwd_val_reg, fwd_val_next;
    logic                          out_valid_reg, out_valid_next;
    logic [vpad_pkg::VOXEL_W-1:0]  out_value_reg, out_value_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_status_reg, out_status_next;

    logic [vpad_pkg::VOXEL_W-1:0]  rd_data;
    logic [vpad_pkg::VOXEL_W-1:0]  s1_value;
    logic                          s1_emit, s1_adv, wr_en;

    // A replica read in the same cycle as the write to its address sees the
    // old contents, so the value being written is forwarded instead.
    always_comb
    begin
        unique case (s1_op_reg.kind)
            vpad_pkg::KIND_DIRECT:  s1_value = s1_op_reg.value;
            vpad_pkg::KIND_REPLICA: s1_value = fwd_hit_reg ? fwd_val_reg : rd_data;
            default:                s1_value = '0;
        endcase
        s1_emit = (s1_op_reg.kind != vpad_pkg::KIND_REJECT);
        s1_adv  = s1_valid_reg && (!out_valid_reg || out_ready);
        pop     = q_valid && (!s1_valid_reg || s1_adv);
        wr_en   = s1_adv && s1_emit;
    end

    vpad_ram #(
        .WIDTH (vpad_pkg::VOXEL_W),
        .DEPTH (vpad_pkg::STORE_DEPTH)
    ) u_slice_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_op_reg.wr_addr),
        .wr_data (s1_value),
        .rd_en   (pop),
        .rd_addr (q_head.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_op_next      = s1_op_reg;
        fwd_hit_next    = fwd_hit_reg;
        fwd_val_next    = fwd_val_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        if (pop)
        begin
            s1_valid_next = 1'b1;
            s1_op_next    = q_head;
            fwd_hit_next  = wr_en && (s1_op_reg.wr_addr == q_head.rd_addr);
            fwd_val_next  = s1_value;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = s1_emit ? s1_value : '0;
            out_last_next   = s1_emit && s1_op_reg.last;
            out_status_next = !s1_emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= s1_op_next;
        fwd_hit_reg    <= fwd_hit_next;
        fwd_val_reg    <= fwd_val_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign last_of_volume = out_last_reg;
    assign status         = out_status_reg;

endmodule

`default_nettype wire

>>> rtl/volume_edge_replicate_pad.sv
// ============================================================================
// Volume edge replicate pad: top level
// Pads a byte volume to a larger size by replicating its high edges, with
// replicas taken from a slice store.
// ============================================================================
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    opcode, voxel_value
//   out      out_valid / out_ready  out_value, last_of_volume, status
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken every cycle while the queue has room; a result passes
// from its request through the queue, the store read and the output register.
// The rate is set by the single read and single write port of the store.
// A four-entry queue lets requests arrive while the output is stalled.
// Reset clears the position, the row register and the sizes to one; the
// store is not cleared.
// ============================================================================
`default_nettype none

module volume_edge_replicate_pad (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [vpad_pkg::VOXEL_W-1:0]      voxel_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [vpad_pkg::VOXEL_W-1:0]      out_value,
    output logic                                   last_of_volume,
    output logic                                   status,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vpad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vpad_pkg::CFG_W-1:0]        cfg_data
);

    vpad_pkg::cfg_t                   cfg_reg, cfg_next;
    vpad_pkg::pad_op_t                front_op;
    vpad_pkg::pad_op_t                q_head;
    logic                             push, q_ready, q_valid, pop;
    logic [vpad_pkg::QCNT_W-1:0]      q_level;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                vpad_pkg::REG_SOURCE_WIDTH:  cfg_next.source_width  = cfg_data;
                vpad_pkg::REG_SOURCE_HEIGHT: cfg_next.source_height = cfg_data;
                vpad_pkg::REG_SOURCE_DEPTH:  cfg_next.source_depth  = cfg_data;
                vpad_pkg::REG_PADDED_WIDTH:  cfg_next.padded_width  = cfg_data;
                vpad_pkg::REG_PADDED_HEIGHT: cfg_next.padded_height = cfg_data;
                vpad_pkg::REG_PADDED_DEPTH:  cfg_next.padded_depth  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width  <= vpad_pkg::CFG_W'(1);
            cfg_reg.source_height <= vpad_pkg::CFG_W'(1);
            cfg_reg.source_depth  <= vpad_pkg::CFG_W'(1);
            cfg_reg.padded_width  <= vpad_pkg::CFG_W'(1);
            cfg_reg.padded_height <= vpad_pkg::CFG_W'(1);
            cfg_reg.padded_depth  <= vpad_pkg::CFG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vpad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .voxel_value (voxel_value),
        .q_ready     (q_ready),
        .push        (push),
        .op          (front_op)
    );

    vpad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .ready   (q_ready),
        .pop     (pop),
        .valid   (q_valid),
        .head    (q_head),
        .level   (q_level)
    );

    vpad_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_value      (out_value),
        .last_of_volume (last_of_volume),
        .status         (status)
    );

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (out_value == '0 && !last_of_volume))
        else $error("Rejected result carries a voxel or an end of volume mark.");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= vpad_pkg::QCNT_W'(vpad_pkg::QUEUE_DEPTH))
        else $error("Operation queue holds more entries than it has slots.");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == vpad_pkg::QCNT_W'(vpad_pkg::QUEUE_DEPTH) && !pop)
            |=> (q_level == vpad_pkg::QCNT_W'(vpad_pkg::QUEUE_DEPTH)))
        else $error("Full queue lost an entry without a pop.");

endmodule

`default_nettype wire
